### hdl/vad_pkg.sv
// vad_pkg: widths, types, constants and the arctangent table of the vector angle block
// self-contained; imported by every module of the block
`default_nettype none

package vad_pkg;

   // coordinate width and CORDIC depth
   localparam int COORD_WIDTH   = 16;
   localparam int CORDIC_STAGES = 16;

   // product and datapath widths
   localparam int PROD_W     = 2 * COORD_WIDTH;
   localparam int PROD_SHIFT = (PROD_W > 32) ? (PROD_W - 32) : 0;
   localparam int SPROD_W    = PROD_W - PROD_SHIFT;
   localparam int DOT_W      = SPROD_W + 1;
   // one more bit for the CORDIC gain of about 1.65
   localparam int XY_W       = DOT_W + 1;
   localparam int Z_W        = 26;
   localparam int STAGE_W    = (CORDIC_STAGES > 1) ? $clog2(CORDIC_STAGES) : 1;
   localparam int TABLE_W    = 5;

   // angle constants in degrees times 65536
   localparam int DEG_ONE      = 65536;
   localparam int QUARTER_TURN = 90 * DEG_ONE;
   localparam int FULL_TURN    = 360 * DEG_ONE;

   // output rounding to Q9.7
   localparam int ROUND_SHIFT = 9;
   localparam int ROUND_BIAS  = 1 << (ROUND_SHIFT - 1);
   localparam int ANGLE_W     = 16;
   localparam int RND_W       = Z_W - ROUND_SHIFT;
   localparam int Q97_FULL    = 46080;

   // three front stages, the cells, output register
   localparam int LATENCY = CORDIC_STAGES + 4;

   typedef logic signed [COORD_WIDTH-1:0] coord_type;
   typedef logic signed [XY_W-1:0]        xy_type;
   typedef logic signed [Z_W-1:0]         z_type;

   typedef struct packed {
      logic   zero;
      xy_type x;
      xy_type y;
      z_type  z;
   } cell_data_type;

   // atan(2^-i) in degrees times 65536, rounded to nearest
   function automatic z_type atan_q16(input logic [TABLE_W-1:0] idx);
      z_type val;
      case (idx)
         5'd0:    val = Z_W'(2949120);
         5'd1:    val = Z_W'(1740967);
         5'd2:    val = Z_W'(919879);
         5'd3:    val = Z_W'(466945);
         5'd4:    val = Z_W'(234379);
         5'd5:    val = Z_W'(117304);
         5'd6:    val = Z_W'(58666);
         5'd7:    val = Z_W'(29335);
         5'd8:    val = Z_W'(14668);
         5'd9:    val = Z_W'(7334);
         5'd10:   val = Z_W'(3667);
         5'd11:   val = Z_W'(1833);
         5'd12:   val = Z_W'(917);
         5'd13:   val = Z_W'(458);
         5'd14:   val = Z_W'(229);
         5'd15:   val = Z_W'(115);
         5'd16:   val = Z_W'(57);
         5'd17:   val = Z_W'(29);
         5'd18:   val = Z_W'(14);
         5'd19:   val = Z_W'(7);
         5'd20:   val = Z_W'(4);
         5'd21:   val = Z_W'(2);
         5'd22:   val = Z_W'(1);
         default: val = '0;
      endcase
      return val;
   endfunction

endpackage

`default_nettype wire

### hdl/vad_front.sv
// vad_front: products, dot and cross sums, and the left half-plane pre-rotation
// depends on vad_pkg
`default_nettype none

module vad_front (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   in_valid,
   input  wire vad_pkg::coord_type     first_x,
   input  wire vad_pkg::coord_type     first_y,
   input  wire vad_pkg::coord_type     second_x,
   input  wire vad_pkg::coord_type     second_y,
   output logic                        out_valid,
   output vad_pkg::cell_data_type      out_data
);
   import vad_pkg::*;

   // stage 1: products
   logic                     p1_valid_ff;
   logic                     p1_zero_ff;
   logic                     p1_zero_in;
   logic signed [PROD_W-1:0] prod_ff [4];
   logic signed [PROD_W-1:0] prod_in [4];

   // stage 2: dot and cross
   logic                     p2_valid_ff;
   logic                     p2_zero_ff;
   logic signed [DOT_W-1:0]  dot_ff, dot_in;
   logic signed [DOT_W-1:0]  cross_ff, cross_in;
   logic signed [SPROD_W-1:0] sprod [4];

   // stage 3: pre-rotated vector
   logic                     p3_valid_ff;
   cell_data_type            p3_data_ff, p3_data_in;
   xy_type                   dot_ext, cross_ext;

   always_comb begin
      prod_in[0] = PROD_W'(first_x) * PROD_W'(second_x);
      prod_in[1] = PROD_W'(first_y) * PROD_W'(second_y);
      prod_in[2] = PROD_W'(first_x) * PROD_W'(second_y);
      prod_in[3] = PROD_W'(first_y) * PROD_W'(second_x);
      p1_zero_in = ((first_x == '0) && (first_y == '0)) ||
                   ((second_x == '0) && (second_y == '0));
   end

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         sprod[k] = SPROD_W'(prod_ff[k] >>> PROD_SHIFT);
      end
      dot_in   = DOT_W'(sprod[0]) + DOT_W'(sprod[1]);
      cross_in = DOT_W'(sprod[2]) - DOT_W'(sprod[3]);
   end

   always_comb begin
      dot_ext   = XY_W'(dot_ff);
      cross_ext = XY_W'(cross_ff);
      p3_data_in.zero = p2_zero_ff || ((dot_ff == '0) && (cross_ff == '0));
      if (dot_ff < 0) begin
         if (cross_ff >= 0) begin
            p3_data_in.x = cross_ext;
            p3_data_in.y = -dot_ext;
            p3_data_in.z = Z_W'(QUARTER_TURN);
         end else begin
            p3_data_in.x = -cross_ext;
            p3_data_in.y = dot_ext;
            p3_data_in.z = -Z_W'(QUARTER_TURN);
         end
      end else begin
         p3_data_in.x = dot_ext;
         p3_data_in.y = cross_ext;
         p3_data_in.z = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
         p2_valid_ff <= 1'b0;
         p3_valid_ff <= 1'b0;
      end else begin
         p1_valid_ff <= in_valid;
         p2_valid_ff <= p1_valid_ff;
         p3_valid_ff <= p2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff    <= prod_in;
      p1_zero_ff <= p1_zero_in;
      dot_ff     <= dot_in;
      cross_ff   <= cross_in;
      p2_zero_ff <= p1_zero_ff;
      p3_data_ff <= p3_data_in;
   end

   assign out_valid = p3_valid_ff;
   assign out_data  = p3_data_ff;

endmodule

`default_nettype wire

### hdl/vad_cell.sv
// vad_cell: one CORDIC vectoring step with its own pipeline register
// depends on vad_pkg
`default_nettype none

module vad_cell (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic [vad_pkg::STAGE_W-1:0]   shift_amt,
   input  wire vad_pkg::z_type                atan_step,
   input  wire logic                          in_valid,
   input  wire vad_pkg::cell_data_type        in_data,
   output logic                               out_valid,
   output vad_pkg::cell_data_type             out_data
);
   import vad_pkg::*;

   logic          valid_ff;
   cell_data_type data_ff, data_in;
   xy_type        dx, dy;

   always_comb begin
      dx = in_data.y >>> shift_amt;
      dy = in_data.x >>> shift_amt;
      data_in.zero = in_data.zero;
      // rotate toward the x axis, sign of y picks the direction
      if (!in_data.y[XY_W-1]) begin
         data_in.x = in_data.x + dx;
         data_in.y = in_data.y - dy;
         data_in.z = in_data.z + atan_step;
      end else begin
         data_in.x = in_data.x - dx;
         data_in.y = in_data.y + dy;
         data_in.z = in_data.z - atan_step;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

`default_nettype wire

### hdl/vector_angle_degrees.sv
// vector_angle_degrees: a result passes, from the accepting edge to the edge that takes it,
// through three front stages, one register per CORDIC cell and the output register
// throughput one transaction per clock; busy is high only during reset, never otherwise
// synchronous active-high reset clears all valid bits; no result is pending after reset
// results appear on rsp_ ports for one cycle with rsp_valid; the receiver cannot stall
// depends on vad_pkg, vad_front, vad_cell
`default_nettype none

module vector_angle_degrees (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   output logic                        busy,
   input  wire vad_pkg::coord_type     req_first_x,
   input  wire vad_pkg::coord_type     req_first_y,
   input  wire vad_pkg::coord_type     req_second_x,
   input  wire vad_pkg::coord_type     req_second_y,
   output logic                        rsp_valid,
   output logic [vad_pkg::ANGLE_W-1:0] rsp_angle_deg
);
   import vad_pkg::*;

   // a transaction enters whenever start is seen outside reset
   logic accept;

   // cell chain: entry 0 is the front end output, the last entry feeds the output stage
   logic          chain_valid [CORDIC_STAGES+1];
   cell_data_type chain_data  [CORDIC_STAGES+1];

   // output stage
   cell_data_type           last_data;
   z_type                   z_wrap;
   logic [Z_W-1:0]          z_biased;
   logic [RND_W-1:0]        rounded;
   logic                    rsp_valid_ff;
   logic [ANGLE_W-1:0]      rsp_angle_ff, rsp_angle_in;

   assign busy   = reset;
   assign accept = start && !busy;

   // products, dot/cross and half-plane fold
   vad_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .first_x   (req_first_x),
      .first_y   (req_first_y),
      .second_x  (req_second_x),
      .second_y  (req_second_y),
      .out_valid (chain_valid[0]),
      .out_data  (chain_data[0])
   );

   // one cell per CORDIC iteration, each with its fixed shift and table angle
   for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
      vad_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .shift_amt (STAGE_W'(i)),
         .atan_step (atan_q16(TABLE_W'(i))),
         .in_valid  (chain_valid[i]),
         .in_data   (chain_data[i]),
         .out_valid (chain_valid[i+1]),
         .out_data  (chain_data[i+1])
      );
   end

   // wrap into one turn, round to Q9.7, fold a full circle and a zero vector to zero
   always_comb begin
      last_data = chain_data[CORDIC_STAGES];
      // accumulated angle stays within half a turn of zero, one correction suffices
      if (last_data.z < 0) begin
         z_wrap = last_data.z + Z_W'(FULL_TURN);
      end else begin
         z_wrap = last_data.z;
      end
      z_biased = Z_W'(z_wrap[Z_W-2:0]) + Z_W'(ROUND_BIAS);
      rounded  = z_biased[Z_W-1:ROUND_SHIFT];
      if (last_data.zero || (rounded >= RND_W'(Q97_FULL))) begin
         rsp_angle_in = '0;
      end else begin
         rsp_angle_in = rounded[ANGLE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= chain_valid[CORDIC_STAGES];
      end
   end

   always_ff @(posedge clock) begin
      rsp_angle_ff <= rsp_angle_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_angle_deg = rsp_angle_ff;

   // every result traces back to a transaction accepted through the front, cell and output registers
   a_rsp_has_source : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, LATENCY))
      else $error("result without a matching transaction");

   // a delivered angle is always below a full turn
   a_angle_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_angle_deg < ANGLE_W'(Q97_FULL)))
      else $error("angle out of range");

   // a zero first vector yields angle zero
   a_zero_vector : assert property (@(posedge clock) disable iff (reset)
      (accept && (req_first_x == '0) && (req_first_y == '0))
         |-> ##LATENCY (!rsp_valid || (rsp_angle_deg == '0)))
      else $error("zero vector gave nonzero angle");

endmodule

`default_nettype wire

### test/tb.sv
// tb: self-checking testbench for vector_angle_degrees, driving vector pairs and checking angles
// predicts each angle with its own dot/cross and cordic arithmetic; depends on vad_pkg and the rtl
`default_nettype none

module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import vad_pkg::*;

   // one accepted pair and the angle it must produce
   typedef struct {
      coord_type             first_x;
      coord_type             first_y;
      coord_type             second_x;
      coord_type             second_y;
      logic [ANGLE_W-1:0]    angle;
   } angle_expect_type;

   // keeps the expected angles in order and compares each result against the oldest one
   class angle_scoreboard;
      angle_expect_type expected_angles[$];
      int               mismatches;
      longint           atan_step_q16[32];

      function new();
         mismatches = 0;
         // atan(2^-i) in degrees, scaled by 65536
         atan_step_q16 = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
                           14668, 7334, 3667, 1833, 917, 458, 229, 115,
                           57, 29, 14, 7, 4, 2, 1, 0,
                           0, 0, 0, 0, 0, 0, 0, 0};
      endfunction

      task report(string msg);
         $display("[%0t] mismatch: %s", $realtime, msg);
         mismatches++;
      endtask

      // angle from the first vector to the second, degrees Q9.7 wrapped into [0, 360)
      function logic [ANGLE_W-1:0] predict_angle(coord_type fx, coord_type fy,
                                                  coord_type sx, coord_type sy);
         longint ax, ay, bx, by, dot, cross_p, x, y, z, nx, ny, dx, dy, rounded;
         longint turn_q16;
         int     stage;
         turn_q16 = 360 * 65536;
         ax = fx;
         ay = fy;
         bx = sx;
         by = sy;
         if ((ax == 0 && ay == 0) || (bx == 0 && by == 0)) return '0;
         dot     = ((ax * bx) >>> PROD_SHIFT) + ((ay * by) >>> PROD_SHIFT);
         cross_p = ((ax * by) >>> PROD_SHIFT) - ((ay * bx) >>> PROD_SHIFT);
         if (dot == 0 && cross_p == 0) return '0;
         x = dot;
         y = cross_p;
         z = 0;
         // left half-plane: pre-rotate by a quarter turn toward the x axis
         if (x < 0) begin
            if (y >= 0) begin
               nx = y;
               ny = -x;
               z  = 90 * 65536;
            end else begin
               nx = -y;
               ny = x;
               z  = -90 * 65536;
            end
            x = nx;
            y = ny;
         end
         for (stage = 0; stage < CORDIC_STAGES && stage < 32; stage++) begin
            dx = y >>> stage;
            dy = x >>> stage;
            if (y >= 0) begin
               x += dx;
               y -= dy;
               z += atan_step_q16[stage];
            end else begin
               x -= dx;
               y += dy;
               z -= atan_step_q16[stage];
            end
         end
         while (z < 0) z += turn_q16;
         while (z >= turn_q16) z -= turn_q16;
         rounded = (z + 256) >>> 9;
         if (rounded >= 46080) rounded = 0;
         return rounded[ANGLE_W-1:0];
      endfunction

      function void note_pair(coord_type fx, coord_type fy, coord_type sx, coord_type sy);
         angle_expect_type item;
         item.first_x  = fx;
         item.first_y  = fy;
         item.second_x = sx;
         item.second_y = sy;
         item.angle    = predict_angle(fx, fy, sx, sy);
         expected_angles.push_back(item);
      endfunction

      task check_angle(logic [ANGLE_W-1:0] got);
         angle_expect_type item;
         if (expected_angles.size() == 0) begin
            report($sformatf("angle %0d arrived with no transaction pending", got));
         end else begin
            item = expected_angles.pop_front();
            if (got !== item.angle)
               report($sformatf("first=(%0d,%0d) second=(%0d,%0d) angle got %0d want %0d",
                                item.first_x, item.first_y, item.second_x, item.second_y,
                                got, item.angle));
         end
      endtask

      function int pending();
         return expected_angles.size();
      endfunction
   endclass

   // generous bound: every transaction taking the longest gap plus pipeline drains
   localparam int CYCLE_LIMIT = 300000;

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   coord_type          req_first_x;
   coord_type          req_first_y;
   coord_type          req_second_x;
   coord_type          req_second_y;
   logic               rsp_valid;
   logic [ANGLE_W-1:0] rsp_angle_deg;

   angle_scoreboard    sb;
   int                 cycles = 0;

   vector_angle_degrees DUT (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_first_x   (req_first_x),
      .req_first_y   (req_first_y),
      .req_second_x  (req_second_x),
      .req_second_y  (req_second_y),
      .rsp_valid     (rsp_valid),
      .rsp_angle_deg (rsp_angle_deg)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // watchdog: a hung pipeline or a lost result ends the run here
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("vector_angle_degrees test failed");
         $finish;
      end
   end

   // input monitor: a transaction is taken at a rising edge with start high and busy low
   always @(posedge clock) begin
      if (!reset && start && !busy)
         sb.note_pair(req_first_x, req_first_y, req_second_x, req_second_y);
   end

   // result monitor: the strobe marks exactly one cycle per angle, no back-pressure
   always @(posedge clock) begin
      if (rsp_valid === 1'b1)
         sb.check_angle(rsp_angle_deg);
   end

   // present one pair from the falling edge and hold it until the block takes it
   task send_pair(int fx, int fy, int sx, int sy);
      @(negedge clock);
      start        <= 1'b1;
      req_first_x  <= coord_type'(fx);
      req_first_y  <= coord_type'(fy);
      req_second_x <= coord_type'(sx);
      req_second_y <= coord_type'(sy);
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   // idle cycles with start low; the data ports carry junk that must be ignored
   task hold_off(int count);
      repeat (count) begin
         @(negedge clock);
         start        <= 1'b0;
         req_first_x  <= coord_type'($urandom());
         req_first_y  <= coord_type'($urandom());
         req_second_x <= coord_type'($urandom());
         req_second_y <= coord_type'($urandom());
      end
   endtask

   // stop sending and let every outstanding angle come back
   task wait_for_drain();
      @(negedge clock);
      start <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   // mostly no gap or a short one, now and then a long stall
   function automatic int pick_gap();
      int roll;
      roll = int'($urandom_range(0, 99));
      if (roll < 50) return 0;
      if (roll < 85) return int'($urandom_range(1, 3));
      if (roll < 97) return int'($urandom_range(4, 10));
      return int'($urandom_range(20, 60));
   endfunction

   // full-range values with extra weight on the extremes and on tiny magnitudes
   function automatic coord_type random_coord();
      int roll;
      roll = int'($urandom_range(0, 15));
      if (roll == 0) return coord_type'(32767);
      if (roll == 1) return coord_type'(-32768);
      if (roll <= 3) return coord_type'(int'($urandom_range(0, 8)) - 4);
      return coord_type'($urandom());
   endfunction

   // random pair, sometimes with the second vector tied to the first
   task send_random_pair();
      coord_type fx, fy, sx, sy;
      int        shape;
      fx    = random_coord();
      fy    = random_coord();
      sx    = random_coord();
      sy    = random_coord();
      shape = int'($urandom_range(0, 11));
      case (shape)
         0: begin
            // parallel: angle zero or the full-turn rounding wrap
            sx = fx;
            sy = fy;
         end
         1: begin
            // antiparallel: dot negative, cross zero
            sx = -fx;
            sy = -fy;
         end
         2: begin
            // perpendicular: dot zero
            sx = -fy;
            sy = fx;
         end
         3: begin
            // nearly parallel, the small angle can fall either side of zero
            sx = fx + coord_type'(int'($urandom_range(0, 4)) - 2);
            sy = fy + coord_type'(int'($urandom_range(0, 4)) - 2);
         end
         default: ;
      endcase
      send_pair(int'(fx), int'(fy), int'(sx), int'(sy));
   endtask

   initial begin : stimulus
      int sent;
      int burst;
      int idx;
      bit no_gaps;
      sb           = new();
      reset        = 1'b1;
      start        = 1'b0;
      req_first_x  = '0;
      req_first_y  = '0;
      req_second_x = '0;
      req_second_y = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: zero vectors, the four quadrants, both half-plane turns, extremes
      send_pair(0, 0, 100, 5);
      send_pair(3, 4, 0, 0);
      send_pair(0, 0, 0, 0);
      send_pair(16, 0, 16, 0);
      send_pair(0, 16, 16, 0);
      send_pair(16, 0, 0, 16);
      send_pair(-16, 0, 16, 0);
      send_pair(-16, 1, 16, 0);
      send_pair(-16, -1, 16, 0);
      send_pair(-16, -16, 16, 0);
      send_pair(-16, 16, 16, 0);
      hold_off(3);
      send_pair(32767, 32767, 32767, 32767);
      send_pair(-32768, -32768, -32768, -32768);
      send_pair(-32768, 32767, 32767, -32768);
      send_pair(32767, -32768, -32768, 32767);
      send_pair(-32768, 0, 0, -32768);
      send_pair(-32768, 0, 32767, 0);
      send_pair(32767, 0, -32768, 0);
      send_pair(0, -32768, 0, 32767);
      // tiny clockwise angle: rounds up to a full turn and wraps to zero
      send_pair(32767, 1, 32767, 0);
      send_pair(32767, -1, 32767, 0);
      send_pair(1, 0, 0, -1);
      send_pair(-1, -1, 1, 1);
      send_pair(1, -32768, 32767, 1);
      wait_for_drain();

      // random part: bursts with and without gaps, one full drain half way
      sent = 0;
      while (sent < 1000) begin
         burst   = int'($urandom_range(10, 60));
         no_gaps = ($urandom_range(0, 3) == 0);
         for (idx = 0; idx < burst && sent < 1000; idx++) begin
            send_random_pair();
            sent++;
            if (!no_gaps) hold_off(pick_gap());
            if (sent == 500) wait_for_drain();
         end
      end

      wait_for_drain();
      repeat (LATENCY + 8) @(posedge clock);
      if (sb.mismatches == 0) begin
         $display("vector_angle_degrees test passed");
      end else begin
         $display("vector_angle_degrees test failed");
      end
      $finish;
   end

endmodule

`default_nettype wire
